// ===== rtl/ffas_pkg.sv =====
package ffas_pkg;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOFIT    = 3'd1,
      ST_TOOBIG   = 3'd2,
      ST_FULL     = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic load_req;     // capture request fields
      logic reset_table;  // reset table to one free block
      logic rd_issue;     // read entry at scan index (the datapath reads every cycle and ignores this)
      logic rem_start;    // start remainder unit on fetched entry
      logic eval;         // evaluate fetched entry (the datapath evaluates on rem_done and ignores this)
      logic wr_hit;       // rewrite entry at scan index
      logic wr_tail;      // append remainder entry
      logic set_free;     // mark entry at scan index free
      logic scan_next;    // advance scan index
      logic scan_clear;   // scan index back to zero
   } ffas_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic op_free;
      logic too_big;
      logic scan_end;     // scan index reached entry count
      logic rem_done;
      logic entry_match;  // free: entry matches
      logic entry_fit;    // alloc: entry fits
      logic exact_fit;
      logic table_full;
   } ffas_stat_type;

endpackage

// ===== rtl/first_fit_aligned_suballocator.sv =====
// Allocate scans entries in order and waits on the remainder unit for each one, with one
//   more table write on a split; free scans without waiting on the remainder unit.
// Throughput: one request at a time; the next start is taken once busy drops.
// The result strobe is one cycle wide; the receiver cannot stall.
// Reset (synchronous): table holds one free block of 65536 bytes at offset 0,
//   written in the first cycle after reset while busy stays high.
// The table is rebuilt as one free block of the new chunk size on every accepted csr write.
module first_fit_aligned_suballocator #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [31:0] req_size,
   input  logic [16:0] req_align,
   input  logic [31:0] req_free_offset,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_granted_offset,
   output logic [31:0] rsp_granted_size,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_chunk_size
);
   import ffas_pkg::*;

   ffas_cmd_type  cmd;
   ffas_stat_type stat;
   status_type    st;
   logic          grant;
   logic [31:0]   chunk_ff;
   logic [31:0]   goff, gsize;
   logic          cfg_write;

   // A pending start wins over a csr write
   assign cfg_write = csr_valid && csr_ready;
   assign csr_ready = !busy && !start;

   // Hold chunk size register
   always_ff @(posedge clock) begin
      if (reset) chunk_ff <= 32'd65536;
      else if (cfg_write) chunk_ff <= csr_chunk_size;
   end

   ffas_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .cfg_write(cfg_write),
      .busy(busy), .cmd(cmd), .stat(stat), .rsp_valid(rsp_strobe),
      .rsp_status(st), .rsp_grant(grant)
   );

   // Reset writes entry 0 through the controller's table reset path too
   ffas_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_op(req_op), .req_size(req_size), .req_align(req_align),
      .req_free_offset(req_free_offset),
      .chunk_size(cfg_write ? csr_chunk_size : chunk_ff),
      .grant_offset(goff), .grant_size(gsize)
   );

   assign rsp_status         = st;
   assign rsp_granted_offset = grant ? goff : 32'd0;
   assign rsp_granted_size   = grant ? gsize : 32'd0;

`ifndef SYNTHESIS
   a_no_strobe_idle_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("result strobe right after start");
   a_strobe_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("busy while result shown");
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |-> (rsp_granted_size == 32'd0))
      else $error("grant on failure");
`endif
endmodule

// ===== rtl/ffas_ram.sv =====
module ffas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/ffas_rem.sv =====
// Restoring remainder: num % den, one quotient bit per cycle
module ffas_rem (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] num,
   input  logic [16:0] den,
   output logic        done,
   output logic [16:0] rem
);
   logic [31:0] num_ff, num_in;
   logic [17:0] acc_ff, acc_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [17:0] trial;

   assign trial = {acc_ff[16:0], num_ff[31]};

   always_comb begin
      num_in  = num_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         acc_in  = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in next bit, subtract when possible
         num_in = {num_ff[30:0], 1'b0};
         acc_in = (trial >= {1'b0, den}) ? trial - {1'b0, den} : trial;
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign rem  = acc_ff[16:0];
endmodule

// ===== rtl/ffas_datapath.sv =====
module ffas_datapath #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ffas_pkg::ffas_cmd_type cmd,
   output ffas_pkg::ffas_stat_type stat,
   input  logic                   req_op,
   input  logic [31:0]            req_size,
   input  logic [16:0]            req_align,
   input  logic [31:0]            req_free_offset,
   input  logic [31:0]            chunk_size,
   output logic [31:0]            grant_offset,
   output logic [31:0]            grant_size
);
   import ffas_pkg::*;

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   logic        op_ff;
   logic [31:0] size_ff, foff_ff;
   logic [16:0] align_ff;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0] rd_off, rd_size;
   logic        rd_free;
   logic [31:0] ent_off_ff, ent_size_ff;
   logic        ent_free_ff;
   logic [31:0] pad_ff, noff_ff;
   logic        fit_ff, exact_ff;
   logic        rem_done;
   logic [16:0] rem;
   logic [31:0] pad, avail, noff;
   logic        wr_en;
   logic        fr_en;
   logic [IW-1:0] wr_addr;
   logic [31:0] wr_off, wr_size;
   logic        wr_free;
   logic [IW-1:0] tail_addr;
   logic [IW-1:0] rd_addr;

   assign tail_addr = count_ff[IW-1:0];
   assign rd_addr   = idx_ff[IW-1:0];

   // Capture request
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_op;
         size_ff  <= req_size;
         foff_ff  <= req_free_offset;
         align_ff <= (req_align == 17'd0) ? 17'd1 : req_align;
      end
   end

   // Table entries
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_addr;
      wr_off  = noff_ff;
      wr_size = size_ff;
      wr_free = 1'b1;
      if (cmd.reset_table) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_off  = '0;
         wr_size = chunk_size;
      end else if (cmd.wr_hit) begin
         wr_en   = 1'b1;
         wr_free = 1'b0;
      end else if (cmd.wr_tail) begin
         wr_en   = 1'b1;
         wr_addr = tail_addr;
         wr_off  = noff_ff + size_ff;
         wr_size = ent_size_ff - pad_ff - size_ff;
      end
   end

   // Free marks also take a release without touching offset and size
   assign fr_en = wr_en || cmd.set_free;

   ffas_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_off_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_off),
      .rd_addr(rd_addr), .rd_data(rd_off)
   );
   ffas_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_size_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_size),
      .rd_addr(rd_addr), .rd_data(rd_size)
   );
   ffas_ram #(.WIDTH(1), .DEPTH(MAX_ENTRIES)) u_free_ram (
      .clock(clock), .wr_en(fr_en), .wr_addr(wr_addr), .wr_data(wr_free),
      .rd_addr(rd_addr), .rd_data(rd_free)
   );

   ffas_rem u_rem (
      .clock(clock), .reset(reset), .start(cmd.rem_start),
      .num(rd_off), .den(align_ff), .done(rem_done), .rem(rem)
   );

   // Scan index and count
   always_comb begin
      idx_in   = idx_ff;
      count_in = count_ff;
      if (cmd.scan_clear) idx_in = '0;
      else if (cmd.scan_next) idx_in = idx_ff + 1'b1;
      if (cmd.reset_table) begin
         count_in = CW'(1);
      end
      if (cmd.wr_tail) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         count_ff <= CW'(1);
      end else begin
         idx_ff   <= idx_in;
         count_ff <= count_in;
      end
   end

   // Latch fetched entry
   always_ff @(posedge clock) begin
      if (cmd.rem_start) begin
         ent_free_ff <= rd_free;
         ent_off_ff  <= rd_off;
         ent_size_ff <= rd_size;
      end
   end

   // Fit evaluation once remainder is known
   assign pad   = (rem != 17'd0) ? {15'd0, align_ff - rem} : 32'd0;
   assign avail = ent_size_ff - pad;
   assign noff  = ent_off_ff + pad;

   always_ff @(posedge clock) begin
      if (rem_done) begin
         pad_ff   <= pad;
         noff_ff  <= noff;
         fit_ff   <= ent_free_ff && (pad <= ent_size_ff) && (avail >= size_ff);
         exact_ff <= (avail == size_ff);
      end
   end

   assign stat.op_free     = op_ff;
   assign stat.too_big     = size_ff > chunk_size;
   assign stat.scan_end    = idx_ff >= count_ff;
   assign stat.rem_done    = rem_done;
   assign stat.entry_match = (ent_off_ff == foff_ff) && (ent_size_ff == size_ff);
   assign stat.entry_fit   = fit_ff;
   assign stat.exact_fit   = exact_ff;
   assign stat.table_full  = count_ff >= CW'(MAX_ENTRIES);

   assign grant_offset = noff_ff;
   assign grant_size   = size_ff;

   logic unused_eval;
   assign unused_eval = cmd.eval | cmd.rd_issue;
endmodule

// ===== rtl/ffas_ctrl.sv =====
module ffas_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    cfg_write,
   output logic                    busy,
   output ffas_pkg::ffas_cmd_type  cmd,
   input  ffas_pkg::ffas_stat_type stat,
   output logic                    rsp_valid,
   output ffas_pkg::status_type    rsp_status,
   output logic                    rsp_grant
);
   import ffas_pkg::*;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_CHECK, S_READ, S_LATCH, S_REM, S_DECIDE, S_WAIT, S_TAIL
   } state_type;

   state_type  state_ff, state_in;
   logic       valid_ff, valid_in;
   status_type status_ff, status_in;
   logic       grant_ff, grant_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      valid_in  = 1'b0;
      status_in = status_ff;
      grant_in  = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.reset_table = 1'b1;
            state_in        = S_IDLE;
         end
         S_IDLE: begin
            if (cfg_write) begin
               cmd.reset_table = 1'b1;
            end else if (start) begin
               cmd.load_req   = 1'b1;
               cmd.scan_clear = 1'b1;
               state_in       = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!stat.op_free && stat.too_big) begin
               valid_in  = 1'b1;
               status_in = ST_TOOBIG;
               state_in  = S_IDLE;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (stat.scan_end) begin
               valid_in  = 1'b1;
               status_in = stat.op_free ? ST_NOTFOUND : ST_NOFIT;
               state_in  = S_IDLE;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = S_LATCH;
            end
         end
         S_LATCH: begin
            cmd.rem_start = 1'b1;
            state_in      = stat.op_free ? S_DECIDE : S_REM;
         end
         S_REM: begin
            if (stat.rem_done) state_in = S_WAIT;
         end
         S_WAIT: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.eval = 1'b1;
            if (stat.op_free) begin
               if (stat.entry_match) begin
                  cmd.set_free = 1'b1;
                  valid_in  = 1'b1;
                  status_in = ST_OK;
                  state_in  = S_IDLE;
               end else begin
                  cmd.scan_next = 1'b1;
                  state_in      = S_READ;
               end
            end else if (stat.entry_fit) begin
               if (stat.exact_fit) begin
                  cmd.wr_hit = 1'b1;
                  valid_in   = 1'b1;
                  status_in  = ST_OK;
                  grant_in   = 1'b1;
                  state_in   = S_IDLE;
               end else if (stat.table_full) begin
                  valid_in  = 1'b1;
                  status_in = ST_FULL;
                  state_in  = S_IDLE;
               end else begin
                  cmd.wr_hit = 1'b1;
                  state_in   = S_TAIL;
               end
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_READ;
            end
         end
         S_TAIL: begin
            // append the remainder after the shrunk block
            cmd.wr_tail = 1'b1;
            valid_in    = 1'b1;
            status_in   = ST_OK;
            grant_in    = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         valid_ff  <= 1'b0;
         status_ff <= ST_OK;
         grant_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         status_ff <= status_in;
         grant_ff  <= grant_in;
      end
   end

   assign busy       = (state_ff != S_IDLE) || reset;
   assign rsp_valid  = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_grant  = grant_ff;
endmodule

// ===== test/tb_first_fit_aligned_suballocator.sv =====
`timescale 1ns / 1ps

module tb_first_fit_aligned_suballocator;
   import ffas_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int ITEM_TARGET = 1750;
   localparam int STALL_LIMIT = 20000;
   localparam logic [31:0] ALIGN_ONE = 32'd1;

   typedef struct {
      status_type  status;
      logic [31:0] offset;
      logic [31:0] size;
   } grant_type;

   typedef struct {
      logic [31:0] offset;
      logic [31:0] size;
   } span_type;

   // Block table mirror and the grants still owed by the block
   class alloc_scoreboard;
      logic [31:0] chunk;
      logic [31:0] offs[TABLE_DEPTH];
      logic [31:0] sizes[TABLE_DEPTH];
      bit          is_free[TABLE_DEPTH];
      int          count;
      grant_type   pending[$];
      span_type    live[$];
      int          errors;
      int          seen[5];

      function void rebuild(logic [31:0] c);
         chunk = c;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            offs[i] = '0;
            sizes[i] = '0;
            is_free[i] = 1'b0;
         end
         sizes[0] = c;
         is_free[0] = 1'b1;
         count = 1;
         live.delete();
      endfunction

      // Predict the grant for one accepted request and update the mirror
      function void note(logic op, logic [31:0] sz, logic [16:0] al, logic [31:0] fo);
         grant_type   g;
         logic [31:0] a, rem, pad, avail, noff;
         g = '{ST_NOTFOUND, 32'd0, 32'd0};
         if (op == OP_FREE) begin
            for (int i = 0; i < count; i++) begin
               if (offs[i] == fo && sizes[i] == sz) begin
                  is_free[i] = 1'b1;
                  g.status = ST_OK;
                  break;
               end
            end
            if (g.status == ST_OK)
               foreach (live[k])
                  if (live[k].offset == fo && live[k].size == sz) begin
                     live.delete(k);
                     break;
                  end
            pending.push_back(g);
            return;
         end
         a = (al == 0) ? ALIGN_ONE : {15'd0, al};
         if (sz > chunk) begin
            g.status = ST_TOOBIG;
         end else begin
            g.status = ST_NOFIT;
            for (int i = 0; i < count; i++) begin
               if (!is_free[i]) continue;
               rem = offs[i] % a;
               pad = (rem != 0) ? a - rem : 32'd0;
               if (pad > sizes[i]) continue;
               avail = sizes[i] - pad;
               if (avail < sz) continue;
               noff = offs[i] + pad;
               if (avail != sz) begin
                  if (count >= TABLE_DEPTH) begin
                     g.status = ST_FULL;
                     break;
                  end
                  // append the remainder as a new free block
                  offs[count] = noff + sz;
                  sizes[count] = avail - sz;
                  is_free[count] = 1'b1;
                  count++;
               end
               offs[i] = noff;
               sizes[i] = sz;
               is_free[i] = 1'b0;
               g = '{ST_OK, noff, sz};
               live.push_back('{noff, sz});
               break;
            end
         end
         pending.push_back(g);
      endfunction

      function void check(logic [2:0] st, logic [31:0] off, logic [31:0] sz);
         grant_type g;
         if (pending.size() == 0) begin
            $display("%0t: unexpected grant status=%0d offset=%h size=%h", $time, st, off, sz);
            errors++;
            return;
         end
         g = pending.pop_front();
         if (st < 5) seen[st]++;
         if (st !== g.status) begin
            $display("%0t: status expected %0d actual %0d", $time, g.status, st);
            errors++;
         end
         if (off !== g.offset) begin
            $display("%0t: granted_offset expected %h actual %h", $time, g.offset, off);
            errors++;
         end
         if (sz !== g.size) begin
            $display("%0t: granted_size expected %h actual %h", $time, g.size, sz);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_op;
   logic [31:0] req_size;
   logic [16:0] req_align;
   logic [31:0] req_free_offset;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_granted_offset;
   logic [31:0] rsp_granted_size;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_chunk_size;

   alloc_scoreboard sb;
   int idle_pct;
   int items_sent;
   int chunk_writes;
   int stall_cycles;

   first_fit_aligned_suballocator uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_size           (req_size),
      .req_align          (req_align),
      .req_free_offset    (req_free_offset),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_granted_size   (rsp_granted_size),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_chunk_size     (csr_chunk_size)
   );

   always #1 clock = ~clock;

   // Check grants and watch for a stuck block
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check(rsp_status, rsp_granted_offset, rsp_granted_size);
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d quiet cycles", STALL_LIMIT);
         $display("tb_first_fit_aligned_suballocator NOT OK");
         $finish;
      end
   end

   // Send one request, holding start until the block takes it
   task automatic issue(logic op, logic [31:0] sz, logic [16:0] al, logic [31:0] fo);
      int gap;
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 8);
         repeat (gap) @(negedge clock);
      end
      req_op = op;
      req_size = sz;
      req_align = al;
      req_free_offset = fo;
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note(op, sz, al, fo);
      items_sent++;
      @(negedge clock);
      start = 1'b0;
   endtask

   // Write chunk_size once the block is idle and every grant has arrived
   task automatic write_chunk(logic [31:0] value);
      while (sb.pending.size() != 0 || busy) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_chunk_size = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.rebuild(value);
      chunk_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [16:0] pick_align();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 17'd1 << $urandom_range(16);
      if (r < 88) return 17'($urandom_range(1, 65536));
      return 17'($urandom);
   endfunction

   // Mostly well-formed allocate and free traffic with some noise
   task automatic random_request();
      int          r, k;
      logic [31:0] sz;
      span_type    s;
      r = $urandom_range(99);
      if (r < 40 || sb.live.size() == 0) begin
         k = $urandom_range(99);
         if (k < 65)
            sz = $urandom_range(0, (sb.chunk >> 3) + 1);
         else if (k < 80)
            sz = $urandom;
         else begin
            sz = 32'd1;
            for (int i = 0; i < sb.count; i++)
               if (sb.is_free[i] && $urandom_range(1)) sz = sb.sizes[i];
         end
         issue(OP_ALLOC, sz, pick_align(), $urandom);
      end else if (r < 85) begin
         s = sb.live[$urandom_range(sb.live.size() - 1)];
         issue(OP_FREE, s.size, 17'($urandom), s.offset);
      end else if (r < 93) begin
         s = sb.live[$urandom_range(sb.live.size() - 1)];
         issue(OP_FREE, s.size + 32'd1, 17'($urandom), s.offset);
      end else begin
         issue(OP_FREE, $urandom, 17'($urandom), $urandom);
      end
   endtask

   initial begin
      int n;
      int phase;
      logic [31:0] c;
      sb = new();
      sb.rebuild(32'd65536);
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_op = OP_ALLOC;
      req_size = '0;
      req_align = 17'd1;
      req_free_offset = '0;
      csr_valid = 1'b0;
      csr_chunk_size = '0;
      idle_pct = 0;
      items_sent = 0;
      chunk_writes = 0;
      stall_cycles = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Edge cases on the reset chunk
      issue(OP_ALLOC, 32'd65537, 17'd1, 32'd0);
      issue(OP_ALLOC, 32'd65536, 17'd1, 32'd0);
      issue(OP_ALLOC, 32'd1, 17'd1, 32'd0);
      issue(OP_FREE, 32'd65536, 17'd1, 32'd0);
      issue(OP_FREE, 32'hFFFF_FFFF, 17'h1FFFF, 32'hFFFF_FFFF);
      issue(OP_ALLOC, 32'd0, 17'd0, 32'd0);
      issue(OP_ALLOC, 32'd100, 17'd65536, 32'd0);
      issue(OP_ALLOC, 32'd10, 17'd3, 32'd0);
      issue(OP_ALLOC, 32'd1, 17'h1FFFF, 32'd0);

      // Padding beyond a block, exact fit, free of an already free block
      write_chunk(32'd100);
      issue(OP_ALLOC, 32'd10, 17'd1, 32'd0);
      issue(OP_ALLOC, 32'd1, 17'd65536, 32'd0);
      issue(OP_ALLOC, 32'd90, 17'd1, 32'd0);
      issue(OP_FREE, 32'd90, 17'd1, 32'd10);
      issue(OP_FREE, 32'd90, 17'd1, 32'd10);
      issue(OP_ALLOC, 32'd0, 17'd1, 32'd0);

      // Largest chunk
      write_chunk(32'hFFFF_FFFF);
      issue(OP_ALLOC, 32'hFFFF_FFFF, 17'd1, 32'd0);
      issue(OP_FREE, 32'hFFFF_FFFF, 17'd1, 32'd0);
      issue(OP_ALLOC, 32'h8000_0000, 17'd65536, 32'd0);
      issue(OP_ALLOC, 32'h7FFF_FFFF, 17'd1, 32'd0);

      // Smallest chunk
      write_chunk(32'd1);
      issue(OP_ALLOC, 32'd2, 17'd1, 32'd0);
      issue(OP_ALLOC, 32'd1, 17'd1, 32'd0);

      // Fill the table until a split is refused, then take the tail exactly
      write_chunk(32'd4096);
      repeat (TABLE_DEPTH) issue(OP_ALLOC, 32'd1, 17'd1, 32'd0);
      issue(OP_ALLOC, 32'd4033, 17'd1, 32'd0);

      // Random phases, each on a fresh chunk, cycling through sender idling
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase % 6)
            0: c = 32'd65536;
            1: c = 32'hFFFF_FFFF;
            2: c = $urandom_range(1, 64);
            3: c = $urandom;
            4: c = $urandom_range(256, 1 << 20);
            default: c = 32'd1 << $urandom_range(31);
         endcase
         if (c == 0) c = 32'd1;
         write_chunk(c);
         idle_pct = (phase % 4 == 1) ? 60 : ((phase % 4 == 3) ? 36 : 0);
         n = $urandom_range(20, 40);
         repeat (n) random_request();
         phase++;
      end

      // Drain and settle
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d requests over %0d chunk settings", items_sent, chunk_writes);
      $display("grants: ok %0d, no fit %0d, too big %0d, table full %0d, not found %0d",
               sb.seen[ST_OK], sb.seen[ST_NOFIT], sb.seen[ST_TOOBIG],
               sb.seen[ST_FULL], sb.seen[ST_NOTFOUND]);
      if (sb.errors == 0)
         $display("tb_first_fit_aligned_suballocator OK");
      else
         $display("tb_first_fit_aligned_suballocator NOT OK");
      $finish;
   end

endmodule

// ===== first_fit_aligned_suballocator.f =====
rtl/ffas_pkg.sv
rtl/ffas_ram.sv
rtl/ffas_rem.sv
rtl/ffas_datapath.sv
rtl/ffas_ctrl.sv
rtl/first_fit_aligned_suballocator.sv
test/tb_first_fit_aligned_suballocator.sv
